/* rtl/wav_pcm_stream_parser_defines.svh */
// ----------------------------------------------------------------------------
// wav pcm stream parser assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_PARSER_DEFINES_SVH
`define WAV_PCM_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
`define WPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/wpp_pkg.sv */
// ----------------------------------------------------------------------------
// wpp_pkg
// shared types and constants of the wav pcm stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package wpp_pkg;

    localparam int unsigned MAX_SAMPLE_BYTES = 4;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [5:0] OFS_FORMAT_LO = 6'd20;
    localparam logic [5:0] OFS_FORMAT_HI = 6'd21;
    localparam logic [5:0] OFS_CHAN_LO   = 6'd22;
    localparam logic [5:0] OFS_CHAN_HI   = 6'd23;
    localparam logic [5:0] OFS_RATE_B0   = 6'd24;
    localparam logic [5:0] OFS_RATE_B1   = 6'd25;
    localparam logic [5:0] OFS_RATE_B2   = 6'd26;
    localparam logic [5:0] OFS_RATE_B3   = 6'd27;
    localparam logic [5:0] OFS_ALIGN_LO  = 6'd32;
    localparam logic [5:0] OFS_ALIGN_HI  = 6'd33;
    localparam logic [5:0] OFS_DEPTH_LO  = 6'd34;
    localparam logic [5:0] OFS_DEPTH_HI  = 6'd35;

    localparam logic [15:0] FORMAT_PCM    = 16'd1;
    localparam logic [23:0] MARKER_PREFIX = 24'h646174;
    localparam logic [7:0]  MARKER_LAST   = 8'h61;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEARCH,
        PH_SKIP,
        PH_SAMPLES,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_FORMAT,
        ERR_CHANNELS,
        ERR_WIDTH
    } t_err;

    typedef enum logic {
        KIND_FRAME,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [7:0]  data;
        logic        right_lane;
        logic [1:0]  lane;
        logic        first;
        logic        last;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] depth;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] left;
        logic [31:0] right;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [15:0] depth;
        t_err        err;
    } t_result;

endpackage

`default_nettype wire

/* rtl/wpp_in_if.sv */
// ----------------------------------------------------------------------------
// wpp_in_if
// byte input channel of the wav pcm stream parser
// ----------------------------------------------------------------------------
`default_nettype none

interface wpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_file;

    modport source (output valid, output data_byte, output new_file, input ready);
    modport sink (input valid, input data_byte, input new_file, output ready);
endinterface

`default_nettype wire

/* rtl/wpp_out_if.sv */
// ----------------------------------------------------------------------------
// wpp_out_if
// result channel of the wav pcm stream parser
// ----------------------------------------------------------------------------
`default_nettype none

interface wpp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] left_sample;
    logic [31:0] right_sample;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output left_sample, output right_sample,
                    output channel_count, output rate_hz, output bits_per_sample,
                    output error_code, input ready);
    modport sink (input valid, input kind, input left_sample, input right_sample,
                  input channel_count, input rate_hz, input bits_per_sample,
                  input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/wav_pcm_stream_parser.sv */
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// wav byte stream parser: header check, data marker search, size skip and
// little-endian sample frame assembly
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  i_in     in   data_byte[7:0], new_file
//  o_out    out  kind, left_sample[31:0], right_sample[31:0], channel_count[15:0],
//                rate_hz[31:0], bits_per_sample[15:0], error_code[1:0]
//
//  one byte accepted per cycle while the command queue is not full, set by the front end state update
//  a result goes from its byte through the queue register, then the output register
//  reset clears control state only, no clearing pass; new_file restarts a file
//  an output stall fills the two-entry command queue, then i_in.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser
    import wpp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wpp_in_if.sink    i_in,
    wpp_out_if.source o_out
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    wpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    wpp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_head),
        .i_pop   (q_pop)
    );

    wpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* rtl/wpp_front.sv */
// ----------------------------------------------------------------------------
// wpp_front
// per-byte parser: header capture and check, marker search, size skip,
// frame byte classification into commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_front
    import wpp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wpp_in_if.sink    i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_hcnt, n_hcnt;
    logic [1:0]  r_skip, n_skip;
    logic [2:0]  r_fidx, n_fidx;
    logic [15:0] r_format, n_format;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_depth, n_depth;
    logic [23:0] r_window, n_window;
    logic [2:0]  r_bps, n_bps;

    logic        accept;
    t_phase      c_phase;
    logic [5:0]  c_hcnt;
    logic [7:0]  b;
    logic        hdr_last;
    logic [15:0] bps_full;
    t_err        hdr_err;
    logic        hit;
    logic        mono;
    logic [3:0]  frame_len;
    logic        is_left;
    logic [2:0]  rpos;
    logic        last;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign c_phase    = i_in.new_file ? PH_HEADER : r_phase;
    assign c_hcnt     = i_in.new_file ? 6'd0 : r_hcnt;
    assign hdr_last   = (c_hcnt == OFS_DEPTH_HI);
    assign hit        = (r_window == MARKER_PREFIX) && (b == MARKER_LAST);
    assign mono       = (r_chan == 16'd1);
    assign bps_full   = mono ? r_align : {1'b0, r_align[15:1]};

    always_comb begin
        priority if (r_format != FORMAT_PCM) begin
            hdr_err = ERR_FORMAT;
        end else if (r_chan == 16'd0 || r_chan > 16'd2) begin
            hdr_err = ERR_CHANNELS;
        end else if (bps_full == 16'd0 || bps_full > 16'(MAX_SAMPLE_BYTES)) begin
            hdr_err = ERR_WIDTH;
        end else begin
            hdr_err = ERR_NONE;
        end
    end

    assign frame_len = mono ? {1'b0, r_bps} : {r_bps, 1'b0};
    assign is_left   = (r_fidx < r_bps);
    assign rpos      = r_fidx - r_bps;
    assign last      = (({1'b0, r_fidx} + 4'd1) >= frame_len);

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = c_phase;
            unique case (c_phase)
                PH_HEADER: begin
                    if (hdr_last) begin
                        n_phase = (hdr_err != ERR_NONE) ? PH_HALT : PH_SEARCH;
                    end
                end
                PH_SEARCH: begin
                    if (hit) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (r_skip == 2'd3) begin
                        n_phase = PH_SAMPLES;
                    end
                end
                PH_SAMPLES: n_phase = PH_SAMPLES;
                PH_HALT:    n_phase = PH_HALT;
                default:    n_phase = PH_HALT;
            endcase
        end
    end

    always_comb begin
        n_hcnt   = r_hcnt;
        n_skip   = r_skip;
        n_fidx   = r_fidx;
        n_format = r_format;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_align  = r_align;
        n_depth  = r_depth;
        n_window = r_window;
        n_bps    = r_bps;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            n_hcnt = c_hcnt;
            unique case (c_phase)
                PH_HEADER: begin
                    unique case (c_hcnt)
                        OFS_FORMAT_LO: n_format[7:0]  = b;
                        OFS_FORMAT_HI: n_format[15:8] = b;
                        OFS_CHAN_LO:   n_chan[7:0]    = b;
                        OFS_CHAN_HI:   n_chan[15:8]   = b;
                        OFS_RATE_B0:   n_rate[7:0]    = b;
                        OFS_RATE_B1:   n_rate[15:8]   = b;
                        OFS_RATE_B2:   n_rate[23:16]  = b;
                        OFS_RATE_B3:   n_rate[31:24]  = b;
                        OFS_ALIGN_LO:  n_align[7:0]   = b;
                        OFS_ALIGN_HI:  n_align[15:8]  = b;
                        OFS_DEPTH_LO:  n_depth[7:0]   = b;
                        OFS_DEPTH_HI:  n_depth[15:8]  = b;
                        default:       n_hcnt         = c_hcnt;
                    endcase
                    if (!hdr_last) begin
                        n_hcnt = c_hcnt + 6'd1;
                    end else if (hdr_err != ERR_NONE) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_ERROR;
                        o_cmd.err   = hdr_err;
                        o_cmd.chan  = r_chan;
                        o_cmd.rate  = r_rate;
                        o_cmd.depth = {b, r_depth[7:0]};
                    end else begin
                        n_bps    = bps_full[2:0];
                        n_window = '0;
                    end
                end
                PH_SEARCH: begin
                    n_window = {r_window[15:0], b};
                    if (hit) begin
                        n_skip = 2'd0;
                    end
                end
                PH_SKIP: begin
                    if (r_skip == 2'd3) begin
                        n_fidx = 3'd0;
                    end else begin
                        n_skip = r_skip + 2'd1;
                    end
                end
                PH_SAMPLES: begin
                    o_push           = 1'b1;
                    o_cmd.kind       = KIND_FRAME;
                    o_cmd.err        = ERR_NONE;
                    o_cmd.data       = b;
                    o_cmd.right_lane = !is_left;
                    o_cmd.lane       = is_left ? r_fidx[1:0] : rpos[1:0];
                    o_cmd.first      = (r_fidx == 3'd0);
                    o_cmd.last       = last;
                    o_cmd.chan       = r_chan;
                    o_cmd.rate       = r_rate;
                    o_cmd.depth      = r_depth;
                    n_fidx           = last ? 3'd0 : r_fidx + 3'd1;
                end
                PH_HALT: n_hcnt = c_hcnt;
                default: n_hcnt = c_hcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= '0;
            r_skip  <= '0;
            r_fidx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_skip  <= n_skip;
            r_fidx  <= n_fidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_format <= n_format;
        r_chan   <= n_chan;
        r_rate   <= n_rate;
        r_align  <= n_align;
        r_depth  <= n_depth;
        r_window <= n_window;
        r_bps    <= n_bps;
    end

endmodule

`default_nettype wire

/* rtl/wpp_cmd_queue.sv */
// ----------------------------------------------------------------------------
// wpp_cmd_queue
// short command queue between the parser front end and the sample back end
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_cmd_queue
    import wpp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/wpp_back.sv */
// ----------------------------------------------------------------------------
// wpp_back
// sample back end: ors frame bytes into left and right lanes, issues frames
// and error reports through the output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "wav_pcm_stream_parser_defines.svh"

module wpp_back
    import wpp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    wpp_out_if.source  o_out
);

    logic [31:0] r_left, n_left;
    logic [31:0] r_right, n_right;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        emits;
    logic        out_free;
    logic [31:0] shifted;
    logic [31:0] base_l;
    logic [31:0] base_r;

    assign emits    = (i_cmd.kind == KIND_ERROR) || i_cmd.last;
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_valid && (!emits || out_free);
    assign shifted  = {24'd0, i_cmd.data} << {i_cmd.lane, 3'b000};
    assign base_l   = i_cmd.first ? 32'd0 : r_left;
    assign base_r   = i_cmd.first ? 32'd0 : r_right;

    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (o_pop) begin
            if (i_cmd.kind == KIND_FRAME) begin
                n_left  = i_cmd.right_lane ? base_l : (base_l | shifted);
                n_right = i_cmd.right_lane ? (base_r | shifted) : base_r;
            end
            if (emits) begin
                n_out_valid = 1'b1;
                n_out.kind  = i_cmd.kind;
                n_out.chan  = i_cmd.chan;
                n_out.rate  = i_cmd.rate;
                n_out.depth = i_cmd.depth;
                n_out.err   = i_cmd.err;
                if (i_cmd.kind == KIND_ERROR) begin
                    n_out.left  = 32'd0;
                    n_out.right = 32'd0;
                end else begin
                    n_out.left  = n_left;
                    n_out.right = (i_cmd.chan == 16'd1) ? n_left : n_right;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        r_out   <= n_out;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = logic'(r_out.kind);
    assign o_out.left_sample     = r_out.left;
    assign o_out.right_sample    = r_out.right;
    assign o_out.channel_count   = r_out.chan;
    assign o_out.rate_hz         = r_out.rate;
    assign o_out.bits_per_sample = r_out.depth;
    assign o_out.error_code      = 2'(r_out.err);

    `WPP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        r_out_valid && r_out.kind == KIND_ERROR,
        r_out.left == 32'd0 && r_out.right == 32'd0 && r_out.err != ERR_NONE)
    `WPP_ASSERT_IMP(a_mono_copy, i_clk, i_rst_n,
        r_out_valid && r_out.kind == KIND_FRAME && r_out.chan == 16'd1,
        r_out.right == r_out.left && r_out.err == ERR_NONE)
    `WPP_ASSERT_NEXT(a_issue_fill, i_clk, i_rst_n, o_pop && emits, r_out_valid)

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wav pcm stream parser: a table of directed
// files (valid formats, header rejects, restarts) followed by random files,
// broken headers and noise; every item is run through a local model of the
// parser and each result is compared field by field, in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wpp_pkg::*;

    typedef struct {
        logic [15:0] fmt;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] align;
        logic [15:0] depth;
        int          frames;
        logic [7:0]  fill;
        bit          fill_rand;
        bit          mark_first;
        int          cut;
        bit          typed;
        t_err        code;
    } t_file_case;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wpp_in_if  in_ch ();
    wpp_out_if out_ch ();

    wav_pcm_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser model state
    t_phase      stage;
    logic [5:0]  hdr_ofs;
    logic [15:0] fmt_word;
    logic [15:0] chans;
    logic [31:0] rate_word;
    logic [15:0] block_align;
    logic [15:0] depth_word;
    logic [23:0] marker_win;
    logic [1:0]  size_left;
    logic [31:0] acc_l;
    logic [31:0] acc_r;
    logic [2:0]  frame_pos;

    t_result awaited_results [$];
    int      mismatches    = 0;
    int      bytes_sent    = 0;
    int      files_sent    = 0;
    int      frames_seen   = 0;
    int      reports_seen  = 0;
    int      hold_requests = 0;
    bit      no_idle       = 1'b0;

    t_file_case directed_files [0:17] = '{
        // first file relies on reset alone, no new_file mark
        '{FORMAT_PCM, 16'd1, 32'd8000, 16'd1, 16'd8, 4, 8'h00, 1'b0, 1'b0, -1, 1'b0, ERR_NONE},
        '{FORMAT_PCM, 16'd2, 32'hFFFF_FFFF, 16'd8, 16'hFFFF, 3, 8'hFF, 1'b0, 1'b1, -1, 1'b0,
          ERR_NONE},
        '{FORMAT_PCM, 16'd2, 32'd44100, 16'd4, 16'd16, 4, 8'h00, 1'b1, 1'b1, -1, 1'b0, ERR_NONE},
        '{FORMAT_PCM, 16'd1, 32'd48000, 16'd3, 16'd24, 3, 8'h00, 1'b1, 1'b1, -1, 1'b0, ERR_NONE},
        // block slack
        '{FORMAT_PCM, 16'd2, 32'd22050, 16'd5, 16'd12, 3, 8'h00, 1'b1, 1'b1, -1, 1'b0, ERR_NONE},
        // restart while streaming samples
        '{FORMAT_PCM, 16'd1, 32'd0, 16'd4, 16'd0, 4, 8'h00, 1'b1, 1'b1, 58, 1'b0, ERR_NONE},
        // restart inside the header
        '{FORMAT_PCM, 16'd2, 32'd96000, 16'd4, 16'd16, 2, 8'h00, 1'b1, 1'b1, 25, 1'b0, ERR_NONE},
        '{16'd3, 16'd2, 32'd48000, 16'd8, 16'd32, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_FORMAT},
        '{16'hFFFF, 16'd1, 32'd8000, 16'd2, 16'd16, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_FORMAT},
        '{16'd0, 16'd1, 32'd8000, 16'd2, 16'd16, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_FORMAT},
        '{FORMAT_PCM, 16'd0, 32'd8000, 16'd2, 16'd16, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1,
          ERR_CHANNELS},
        '{FORMAT_PCM, 16'd3, 32'd8000, 16'd6, 16'd16, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1,
          ERR_CHANNELS},
        '{FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 2, 8'h00, 1'b1, 1'b1, -1,
          1'b1, ERR_CHANNELS},
        '{FORMAT_PCM, 16'd1, 32'd8000, 16'd5, 16'd40, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_WIDTH},
        // zero sample width
        '{FORMAT_PCM, 16'd2, 32'd8000, 16'd1, 16'd8, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_WIDTH},
        '{FORMAT_PCM, 16'd2, 32'd8000, 16'd10, 16'd40, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_WIDTH},
        '{FORMAT_PCM, 16'd1, 32'd8000, 16'd0, 16'd0, 2, 8'h00, 1'b1, 1'b1, -1, 1'b1, ERR_WIDTH},
        '{FORMAT_PCM, 16'd1, 32'd11025, 16'd2, 16'd16, 3, 8'h00, 1'b1, 1'b1, -1, 1'b0, ERR_NONE}
    };

    function automatic t_result make_result(input t_kind kind, input logic [31:0] l,
                                            input logic [31:0] r, input t_err code);
        make_result = '{kind, l, r, chans, rate_word, depth_word, code};
    endfunction

    task automatic clear_parser();
        stage       = PH_HEADER;
        hdr_ofs     = '0;
        fmt_word    = '0;
        chans       = '0;
        rate_word   = '0;
        block_align = '0;
        depth_word  = '0;
        marker_win  = '0;
        size_left   = '0;
        acc_l       = '0;
        acc_r       = '0;
        frame_pos   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic nf, output bit got,
                              output t_result r);
        int unsigned width_b;
        int unsigned flen;
        int unsigned p;
        got = 1'b0;
        r   = '0;
        if (nf) clear_parser();
        case (stage)
            PH_HEADER: begin
                case (hdr_ofs)
                    OFS_FORMAT_LO: fmt_word[7:0]     = b;
                    OFS_FORMAT_HI: fmt_word[15:8]    = b;
                    OFS_CHAN_LO:   chans[7:0]        = b;
                    OFS_CHAN_HI:   chans[15:8]       = b;
                    OFS_RATE_B0:   rate_word[7:0]    = b;
                    OFS_RATE_B1:   rate_word[15:8]   = b;
                    OFS_RATE_B2:   rate_word[23:16]  = b;
                    OFS_RATE_B3:   rate_word[31:24]  = b;
                    OFS_ALIGN_LO:  block_align[7:0]  = b;
                    OFS_ALIGN_HI:  block_align[15:8] = b;
                    OFS_DEPTH_LO:  depth_word[7:0]   = b;
                    OFS_DEPTH_HI:  depth_word[15:8]  = b;
                    default: ;
                endcase
                if (hdr_ofs < OFS_DEPTH_HI) begin
                    hdr_ofs++;
                end else begin
                    width_b = (chans == 0) ? 0 : block_align / chans;
                    got = 1'b1;
                    if (fmt_word != FORMAT_PCM) begin
                        stage = PH_HALT;
                        r = make_result(KIND_ERROR, '0, '0, ERR_FORMAT);
                    end else if (chans == 0 || chans > 2) begin
                        stage = PH_HALT;
                        r = make_result(KIND_ERROR, '0, '0, ERR_CHANNELS);
                    end else if (width_b == 0 || width_b > MAX_SAMPLE_BYTES) begin
                        stage = PH_HALT;
                        r = make_result(KIND_ERROR, '0, '0, ERR_WIDTH);
                    end else begin
                        got = 1'b0;
                        stage = PH_SEARCH;
                        marker_win = '0;
                    end
                end
            end
            PH_SEARCH: begin
                if (marker_win == MARKER_PREFIX && b == MARKER_LAST) begin
                    stage = PH_SKIP;
                    size_left = '0;
                end
                marker_win = {marker_win[15:0], b};
            end
            PH_SKIP: begin
                if (size_left == 2'd3) begin
                    stage = PH_SAMPLES;
                    frame_pos = '0;
                    acc_l = '0;
                    acc_r = '0;
                end else begin
                    size_left++;
                end
            end
            PH_SAMPLES: begin
                width_b = (chans == 0) ? 0 : block_align / chans;
                if (width_b == 0 || width_b > MAX_SAMPLE_BYTES || chans == 0 || chans > 2) begin
                    stage = PH_HALT;
                end else begin
                    flen = width_b * chans;
                    p = frame_pos;
                    if (p < width_b) acc_l |= 32'(b) << (8 * p);
                    else if (p - width_b < width_b) acc_r |= 32'(b) << (8 * (p - width_b));
                    if (p + 1 >= flen) begin
                        got = 1'b1;
                        r = make_result(KIND_FRAME, acc_l, (chans == 1) ? acc_l : acc_r,
                                        ERR_NONE);
                        acc_l = '0;
                        acc_r = '0;
                        frame_pos = '0;
                    end else begin
                        frame_pos = 3'(p + 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] seen);
        $display("mismatch at result %0d, %s: expected %0h, got %0h",
                 frames_seen + reports_seen, what, want, seen);
        mismatches++;
    endtask

    task automatic check_result();
        t_result want;
        t_result seen;
        seen = '{t_kind'(out_ch.kind), out_ch.left_sample, out_ch.right_sample,
                 out_ch.channel_count, out_ch.rate_hz, out_ch.bits_per_sample,
                 t_err'(out_ch.error_code)};
        if (awaited_results.size() == 0) begin
            report("result with nothing expected", '0, 32'(seen.kind));
            return;
        end
        want = awaited_results.pop_front();
        if (seen.kind != want.kind) report("kind", 32'(want.kind), 32'(seen.kind));
        if (seen.left != want.left) report("left_sample", want.left, seen.left);
        if (seen.right != want.right) report("right_sample", want.right, seen.right);
        if (seen.chan != want.chan) report("channel_count", 32'(want.chan), 32'(seen.chan));
        if (seen.rate != want.rate) report("rate_hz", want.rate, seen.rate);
        if (seen.depth != want.depth) report("bits_per_sample", 32'(want.depth),
                                             32'(seen.depth));
        if (seen.err != want.err) report("error_code", 32'(want.err), 32'(seen.err));
        if (want.kind == KIND_FRAME) frames_seen++;
        else reports_seen++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic nf, input bit use_typed,
                             input t_result typed_r);
        bit      got;
        t_result r;
        while (!no_idle && $urandom_range(0, 99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.new_file  <= nf;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        parse_byte(b, nf, got, r);
        if (got) awaited_results.push_back(use_typed ? typed_r : r);
        bytes_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_file(input t_file_case fc);
        logic [7:0]  img [$];
        int unsigned bps;
        int          flen;
        int          junk;
        t_result     typed_r;
        for (int i = 0; i < 36; i++) img.push_back(8'($urandom_range(0, 255)));
        img[20] = fc.fmt[7:0];
        img[21] = fc.fmt[15:8];
        img[22] = fc.chans[7:0];
        img[23] = fc.chans[15:8];
        for (int i = 0; i < 4; i++) img[24 + i] = fc.rate[8 * i +: 8];
        // marker prefix inside the header must not count
        img[29] = MARKER_PREFIX[23:16];
        img[30] = MARKER_PREFIX[15:8];
        img[31] = MARKER_PREFIX[7:0];
        img[32] = fc.align[7:0];
        img[33] = fc.align[15:8];
        img[34] = fc.depth[7:0];
        img[35] = fc.depth[15:8];
        img.push_back(MARKER_LAST);
        junk = $urandom_range(0, 5);
        for (int i = 0; i < junk; i++) img.push_back(8'($urandom_range(0, 255)));
        img.push_back(MARKER_PREFIX[23:16]);
        img.push_back(MARKER_PREFIX[23:16]);
        img.push_back(MARKER_PREFIX[15:8]);
        img.push_back(MARKER_PREFIX[7:0]);
        img.push_back(MARKER_LAST);
        for (int i = 0; i < 4; i++) img.push_back(8'($urandom_range(0, 255)));
        bps = (fc.chans == 0) ? 0 : fc.align / fc.chans;
        flen = (bps >= 1 && bps <= MAX_SAMPLE_BYTES && fc.chans >= 1 && fc.chans <= 2) ?
               int'(bps * fc.chans) : 4;
        for (int i = 0; i < fc.frames * flen; i++)
            img.push_back(fc.fill_rand ? 8'($urandom_range(0, 255)) : fc.fill);
        typed_r = '{KIND_ERROR, 32'd0, 32'd0, fc.chans, fc.rate, fc.depth, fc.code};
        for (int i = 0; i < img.size() && (fc.cut < 0 || i < fc.cut); i++)
            send_item(img[i], (i == 0) && fc.mark_first, fc.typed && i == OFS_DEPTH_HI,
                      typed_r);
        files_sent++;
    endtask

    initial begin
        int   stall_left;
        int   holds_seen;
        stall_left = 0;
        holds_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) check_result();
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        t_file_case fc;
        int         directed_bytes;
        int         rand_bytes;
        bit         held;
        bit         drained;
        int         pick;
        int         n;
        int         bps;
        held    = 1'b0;
        drained = 1'b0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.new_file  <= 1'b0;
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_files[i]) send_file(directed_files[i]);
        drain();
        directed_bytes = bytes_sent;

        rand_bytes = 0;
        while (bytes_sent < 1900) begin
            no_idle = (rand_bytes >= 100 && rand_bytes < 400);
            if (!held && rand_bytes >= 450) begin
                held = 1'b1;
                hold_requests++;
            end
            if (!drained && rand_bytes >= 650) begin
                drained = 1'b1;
                drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++)
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
            end else begin
                fc.fmt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : FORMAT_PCM;
                n = $urandom_range(0, 19);
                fc.chans = (n == 0) ? 16'($urandom_range(0, 65535)) : (n < 10) ? 16'd1 : 16'd2;
                bps = $urandom_range(1, MAX_SAMPLE_BYTES);
                fc.align = 16'(bps * fc.chans);
                if (fc.chans == 2 && $urandom_range(0, 3) == 0) fc.align++;
                if ($urandom_range(0, 19) == 0) fc.align = 16'($urandom_range(0, 65535));
                fc.rate       = $urandom;
                fc.depth      = 16'($urandom_range(0, 65535));
                fc.frames     = $urandom_range(1, 6);
                fc.fill       = '0;
                fc.fill_rand  = 1'b1;
                fc.mark_first = ($urandom_range(0, 19) != 0);
                fc.cut        = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : -1;
                fc.typed      = 1'b0;
                fc.code       = ERR_NONE;
                send_file(fc);
            end
            rand_bytes = bytes_sent - directed_bytes;
        end
        no_idle = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report("results never delivered", 32'(awaited_results.size()), '0);
        $display("sent %0d bytes in %0d files and noise bursts, %0d directed",
                 bytes_sent, files_sent, directed_bytes);
        $display("checked %0d sample frames and %0d header error reports",
                 frames_seen, reports_seen);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* wav_pcm_stream_parser.f */
+incdir+rtl
rtl/wpp_pkg.sv
rtl/wpp_in_if.sv
rtl/wpp_out_if.sv
rtl/wpp_front.sv
rtl/wpp_cmd_queue.sv
rtl/wpp_back.sv
rtl/wav_pcm_stream_parser.sv
verif/tb.sv
